// ===== src/pbu_pkg.sv =====
// Shared types, codes and constants of the pixel blend unit.
`timescale 1ns / 1ps

package pbu_pkg;

   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 3;
   localparam int PROD_W      = 2 * CHAN_W;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam int SEL_W       = 2;

   localparam logic [CHAN_W-1:0] CHAN_MAX    = {CHAN_W{1'b1}};
   localparam logic [PROD_W:0]   ROUND_BIAS  = (PROD_W + 1)'(128);

   typedef logic [CHAN_W-1:0] chan_type;
   typedef chan_type [NUM_CHAN-1:0] pixel_type;

   typedef enum logic [2:0] {
      FUNC_ADD        = 3'd0,
      FUNC_MULTIPLY   = 3'd1,
      FUNC_SUBTRACT   = 3'd2,
      FUNC_SCREEN     = 3'd3,
      FUNC_OVERLAY    = 3'd4,
      FUNC_ADD_CONST  = 3'd5,
      FUNC_SCALE      = 3'd6,
      FUNC_REPLICATE  = 3'd7
   } func_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_VALUE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_CHANNEL = 1'b1;

   localparam logic [SEL_W-1:0] SEL_BLUE  = 2'd0;
   localparam logic [SEL_W-1:0] SEL_GREEN = 2'd1;
   localparam logic [SEL_W-1:0] SEL_RED   = 2'd2;

   // What the back end of a lane does with its operands.
   typedef enum logic [1:0] {
      LANE_DIRECT    = 2'd0,   // result already known, pass it
      LANE_ROUND     = 2'd1,   // round(a*b/255)
      LANE_ROUND_INV = 2'd2,   // 255 - round(a*b/255)
      LANE_SAT       = 2'd3    // min(a*b, 255)
   } lane_mode_type;

   typedef struct packed {
      lane_mode_type mode;
      chan_type      opa;
      chan_type      opb;
      chan_type      direct;
   } lane_op_type;

   typedef lane_op_type [NUM_CHAN-1:0] lane_ops_type;

endpackage

// ===== src/pbu_decode.sv =====
// First pipeline stage: mode decode, operand setup and the adder-only results.
`timescale 1ns / 1ps

module pbu_decode
   import pbu_pkg::*;
(
   input  logic                clock,
   input  logic [2:0]          func,
   input  pixel_type           top_pix,
   input  pixel_type           bottom_pix,
   input  chan_type            channel_value,
   input  logic [SEL_W-1:0]    target_channel,
   output lane_ops_type        ops_ff
);

   lane_ops_type           ops_in;
   logic [CHAN_W:0]        add_sum [NUM_CHAN];
   chan_type               add_sat [NUM_CHAN];
   chan_type               sub_res [NUM_CHAN];
   chan_type               top_sel;
   logic                   sel_ok;
   logic [CHAN_W:0]        const_sum;
   chan_type               const_sat;

   // pick the configured channel of the top pixel
   always_comb begin
      top_sel = top_pix[0];
      sel_ok  = 1'b1;
      case (target_channel)
         SEL_BLUE:  top_sel = top_pix[0];
         SEL_GREEN: top_sel = top_pix[1];
         SEL_RED:   top_sel = top_pix[2];
         default: begin
            top_sel = top_pix[0];
            sel_ok  = 1'b0;
         end
      endcase
   end

   assign const_sum = {1'b0, top_sel} + {1'b0, channel_value};
   assign const_sat = const_sum[CHAN_W] ? CHAN_MAX : const_sum[CHAN_W-1:0];

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         add_sum[i] = {1'b0, top_pix[i]} + {1'b0, bottom_pix[i]};
         add_sat[i] = add_sum[i][CHAN_W] ? CHAN_MAX : add_sum[i][CHAN_W-1:0];
         sub_res[i] = (top_pix[i] > bottom_pix[i]) ? (top_pix[i] - bottom_pix[i])
                                                   : '0;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         ops_in[i].mode   = LANE_DIRECT;
         ops_in[i].opa    = '0;
         ops_in[i].opb    = '0;
         ops_in[i].direct = top_pix[i];
         case (func_type'(func))
            FUNC_ADD: ops_in[i].direct = add_sat[i];
            FUNC_MULTIPLY: begin
               ops_in[i].mode = LANE_ROUND;
               ops_in[i].opa  = top_pix[i];
               ops_in[i].opb  = bottom_pix[i];
            end
            FUNC_SUBTRACT: ops_in[i].direct = sub_res[i];
            FUNC_SCREEN: begin
               ops_in[i].mode = LANE_ROUND_INV;
               ops_in[i].opa  = ~top_pix[i];
               ops_in[i].opb  = ~bottom_pix[i];
            end
            FUNC_OVERLAY: begin
               // dark bottom: 2ab, light bottom: screen with doubled inverse
               if (!bottom_pix[i][CHAN_W-1]) begin
                  ops_in[i].mode = LANE_ROUND;
                  ops_in[i].opa  = top_pix[i];
                  ops_in[i].opb  = {bottom_pix[i][CHAN_W-2:0], 1'b0};
               end else begin
                  ops_in[i].mode = LANE_ROUND_INV;
                  ops_in[i].opa  = ~top_pix[i];
                  ops_in[i].opb  = {~bottom_pix[i][CHAN_W-2:0], 1'b0};
               end
            end
            FUNC_ADD_CONST: begin
               if (sel_ok && (target_channel == SEL_W'(i))) begin
                  ops_in[i].direct = const_sat;
               end
            end
            FUNC_SCALE: begin
               if (sel_ok && (target_channel == SEL_W'(i))) begin
                  ops_in[i].mode = LANE_SAT;
                  ops_in[i].opa  = top_sel;
                  ops_in[i].opb  = channel_value;
               end
            end
            FUNC_REPLICATE: begin
               if (sel_ok) begin
                  ops_in[i].direct = top_sel;
               end
            end
            default: ops_in[i].direct = top_pix[i];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ops_ff <= ops_in;
   end

endmodule

// ===== src/pbu_lane.sv =====
// Second and third pipeline stages of one color channel: multiply, then round or clamp.
`timescale 1ns / 1ps

module pbu_lane
   import pbu_pkg::*;
(
   input  logic          clock,
   input  lane_op_type   op,
   output chan_type      result_ff
);

   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  prod_in;
   lane_mode_type      mode_ff;
   chan_type           direct_ff;
   logic [PROD_W:0]    biased;
   logic [PROD_W:0]    folded;
   chan_type           rounded;
   chan_type           result_in;

   assign prod_in = PROD_W'(op.opa) * PROD_W'(op.opb);

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      mode_ff   <= op.mode;
      direct_ff <= op.direct;
   end

   // round(p/255) = (t + (t >> 8)) >> 8 with t = p + 128, exact up to 255*255
   assign biased  = {1'b0, prod_ff} + ROUND_BIAS;
   assign folded  = biased + (biased >> CHAN_W);
   assign rounded = folded[2*CHAN_W-1:CHAN_W];

   always_comb begin
      case (mode_ff)
         LANE_DIRECT:    result_in = direct_ff;
         LANE_ROUND:     result_in = rounded;
         LANE_ROUND_INV: result_in = ~rounded;
         LANE_SAT:       result_in = (|prod_ff[PROD_W-1:CHAN_W]) ? CHAN_MAX
                                                                 : prod_ff[CHAN_W-1:0];
         default:        result_in = direct_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule

// ===== src/pixel_blend_unit.sv =====
// Top level of the pixel blend unit: config registers, valid chain and three channel lanes.
`timescale 1ns / 1ps
//
// Blends one BGR pixel of a top layer with one of a bottom layer per beat.
// Input channel: raise start with req_func and the six req_ channel values;
// the beat is taken at any rising edge where start is high and busy is low.
// busy never rises: the pipeline takes a new beat in every cycle.
// Result channel: rsp_valid marks the cycle in which rsp_out_blue,
// rsp_out_green and rsp_out_red hold one result beat. It is shown for one
// cycle only and the receiver has no way to hold it off.
// Each beat passes stages 1, 2 and 3 below in order, each of them registered.
// Throughput: one pixel per clock, sustained.
// Stage 1 decodes the mode and does adds, subtracts and channel selection;
// stage 2 holds one 8x8 multiplier per channel; stage 3 rounds the product
// to /255 (shift-and-add) or clamps it, and registers the result.
// Config: csr_write_enable writes csr_write_data into register csr_index
// (0 channel_value, 1 target_channel) at the clock edge. Change config only
// while no beat is in flight.
// Reset (synchronous, active high) clears both config registers and drops
// every beat in flight; no result appears for beats accepted before it.
//
module pixel_blend_unit
   import pbu_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [2:0]              req_func,
   input  logic [CHAN_W-1:0]       req_top_blue,
   input  logic [CHAN_W-1:0]       req_top_green,
   input  logic [CHAN_W-1:0]       req_top_red,
   input  logic [CHAN_W-1:0]       req_bottom_blue,
   input  logic [CHAN_W-1:0]       req_bottom_green,
   input  logic [CHAN_W-1:0]       req_bottom_red,
   output logic                    rsp_valid,
   output logic [CHAN_W-1:0]       rsp_out_blue,
   output logic [CHAN_W-1:0]       rsp_out_green,
   output logic [CHAN_W-1:0]       rsp_out_red,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data
);

   chan_type            channel_value_ff;
   chan_type            channel_value_in;
   logic [SEL_W-1:0]    target_channel_ff;
   logic [SEL_W-1:0]    target_channel_in;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                s2_valid_ff;
   logic                s3_valid_ff;

   pixel_type           top_pix;
   pixel_type           bottom_pix;
   lane_ops_type        ops;
   pixel_type           result;

   // the pipeline never stalls, so a beat is taken whenever start is high
   assign busy = 1'b0;

   // config register writes; an index with no register behind it drops the write
   always_comb begin
      channel_value_in  = channel_value_ff;
      target_channel_in = target_channel_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CHANNEL_VALUE:  channel_value_in  = csr_write_data[CHAN_W-1:0];
            CSR_TARGET_CHANNEL: target_channel_in = csr_write_data[SEL_W-1:0];
            default: begin
               channel_value_in  = channel_value_ff;
               target_channel_in = target_channel_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_value_ff  <= '0;
         target_channel_ff <= '0;
      end else begin
         channel_value_ff  <= channel_value_in;
         target_channel_ff <= target_channel_in;
      end
   end

   // valid bits travel alongside the three data stages
   assign s1_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // channel order inside a pixel: blue, green, red
   assign top_pix    = {req_top_red, req_top_green, req_top_blue};
   assign bottom_pix = {req_bottom_red, req_bottom_green, req_bottom_blue};

   pbu_decode u_decode (
      .clock          (clock),
      .func           (req_func),
      .top_pix        (top_pix),
      .bottom_pix     (bottom_pix),
      .channel_value  (channel_value_ff),
      .target_channel (target_channel_ff),
      .ops_ff         (ops)
   );

   for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
      pbu_lane u_lane (
         .clock     (clock),
         .op        (ops[g]),
         .result_ff (result[g])
      );
   end

   assign rsp_valid     = s3_valid_ff;
   assign rsp_out_blue  = result[0];
   assign rsp_out_green = result[1];
   assign rsp_out_red   = result[2];

endmodule

// ===== src/pbu_checker.sv =====
// Port-level checks of the pixel blend unit and the bind that attaches them.
`timescale 1ns / 1ps

module pbu_checker
   import pbu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [2:0]          req_func,
   input  logic [CHAN_W-1:0]   req_top_blue,
   input  logic [CHAN_W-1:0]   req_bottom_blue,
   input  logic                rsp_valid,
   input  logic [CHAN_W-1:0]   rsp_out_blue
);

   // every accepted beat shows up as a result strobe
   a_beat_delivered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("accepted beat not delivered after three cycles");

   // no result without a matching beat taken earlier
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("result strobe without a matching accepted beat");

   // multiply by full white keeps the top value
   a_mult_white: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_MULTIPLY && req_bottom_blue == CHAN_MAX)
      |-> ##3 (rsp_out_blue == $past(req_top_blue, 3)))
      else $error("multiply by white changed the top value");

   // screen over black keeps the top value
   a_screen_black: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_SCREEN && req_bottom_blue == '0)
      |-> ##3 (rsp_out_blue == $past(req_top_blue, 3)))
      else $error("screen over black changed the top value");

   // subtract never exceeds the top value
   a_sub_bound: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_SUBTRACT)
      |-> ##3 (rsp_out_blue <= $past(req_top_blue, 3)))
      else $error("subtract result above the top value");

endmodule

bind pixel_blend_unit pbu_checker u_pbu_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_func        (req_func),
   .req_top_blue    (req_top_blue),
   .req_bottom_blue (req_bottom_blue),
   .rsp_valid       (rsp_valid),
   .rsp_out_blue    (rsp_out_blue)
);
